/* hw/rtl/smaf_pkg.sv */
// ----------------------------------------------------------------------------
// smaf_pkg
// Shared widths, reset values, register codes, state codes and the status
// record of the serial units of the scaled moving average filter.
// ----------------------------------------------------------------------------
package smaf_pkg;

	localparam int RAW_W    = 12;               // converter reading
	localparam int GAIN_W   = 21;               // Q16 gain
	localparam int WIN_W_REG = 7;               // window register
	localparam int VAL_W    = 17;               // result value
	localparam int FRAC_W   = 16;               // fraction bits of the gain
	localparam int PROD_W   = RAW_W + GAIN_W;   // full product
	localparam int CFG_IDX_W = 2;

	localparam logic [WIN_W_REG-1:0] WINDOW_RESET = 7'd10;
	localparam logic [GAIN_W-1:0]    GAIN_RESET   = 21'd160044;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FILTER_ENABLE = 2'd0,
		REG_WINDOW        = 2'd1,
		REG_GAIN          = 2'd2
	} cfg_reg_e;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_WRITE,
		ST_IMOD,
		ST_SUM,
		ST_DIVS,
		ST_DIVW,
		ST_DONE
	} state_t;

	// Status of a serial arithmetic unit; done pulses for one cycle.
	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

endpackage

/* hw/rtl/smaf_if.sv */
// ----------------------------------------------------------------------------
// smaf_if
// Valid/ready channels of the filter: converter samples in, values out.
// ----------------------------------------------------------------------------
interface smaf_sample_if;
	logic                       valid;
	logic                       ready;
	logic [smaf_pkg::RAW_W-1:0] raw_sample;

	modport source (output valid, output raw_sample, input ready);
	modport sink   (input valid, input raw_sample, output ready);
endinterface

interface smaf_result_if;
	logic                       valid;
	logic                       ready;
	logic [smaf_pkg::VAL_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

/* hw/rtl/smaf_ram.sv */
// ----------------------------------------------------------------------------
// smaf_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module smaf_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* hw/rtl/smaf_mult.sv */
// ----------------------------------------------------------------------------
// smaf_mult
// Bit-serial shift-add multiplier: one bit of the sample per cycle.
// ----------------------------------------------------------------------------
module smaf_mult (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [smaf_pkg::RAW_W-1:0]  raw,
	input  logic [smaf_pkg::GAIN_W-1:0] gain,
	output smaf_pkg::unit_sts_t         sts,
	output logic [smaf_pkg::PROD_W-1:0] product
);

	localparam int CNT_W = $clog2(smaf_pkg::RAW_W + 1);

	logic [smaf_pkg::PROD_W-1:0] acc_q;
	logic [smaf_pkg::GAIN_W-1:0] gain_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [smaf_pkg::GAIN_W:0]   part;

	// add the gain into the upper half when the current multiplier bit is set
	assign part = {1'b0, acc_q[smaf_pkg::PROD_W-1:smaf_pkg::RAW_W]}
		+ (acc_q[0] ? {1'b0, gain_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(smaf_pkg::RAW_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q  <= {{smaf_pkg::GAIN_W{1'b0}}, raw};
			gain_q <= gain;
		end else if (busy_q) begin
			acc_q <= {part, acc_q[smaf_pkg::RAW_W-1:1]};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign product  = acc_q;

endmodule

/* hw/rtl/smaf_div.sv */
// ----------------------------------------------------------------------------
// smaf_div
// Restoring divider, one quotient bit per cycle; gives quotient and remainder.
// ----------------------------------------------------------------------------
module smaf_div #(
	parameter int N = 23,
	parameter int D = 7
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [N-1:0]        dividend,
	input  logic [D-1:0]        divisor,
	output smaf_pkg::unit_sts_t sts,
	output logic [N-1:0]        quotient,
	output logic [D-1:0]        remainder
);

	localparam int CNT_W = $clog2(N + 1);

	logic [D-1:0]     rem_q;
	logic [N-1:0]     quo_q;
	logic [D-1:0]     dsr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [D:0]       trial;
	logic [D:0]       diff;
	logic             ge;

	assign trial = {rem_q, quo_q[N-1]};
	assign ge    = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(N - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			// partial remainder stays below the divisor, so D bits hold it
			rem_q <= ge ? diff[D-1:0] : trial[D-1:0];
			quo_q <= {quo_q[N-2:0], ge};
		end
	end

	assign sts.busy  = busy_q;
	assign sts.done  = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

/* hw/rtl/scaled_moving_average_filter.sv */
// ----------------------------------------------------------------------------
// scaled_moving_average_filter
// Scales 12-bit converter samples to hundredths of a unit (raw*gain>>16) and
// optionally averages the last window values held in a sample store.
// ----------------------------------------------------------------------------
// Usage:
//   sample_ch carries one raw_sample per request; result_ch returns exactly
//   one value per request, in order. Registers are written through wr_en,
//   wr_index and wr_data: index 0 filter enable, 1 window (1..DEPTH,
//   zero acts as 1, larger saturates), 2 Q16 gain. The user writes them
//   only while the block is idle; the block itself does not enforce this.
//   Work is serial: the product takes one sample bit per cycle in a
//   shift-add multiplier; with the filter on, the value is stored, the
//   store is swept one entry per cycle (bounded by the single RAM read
//   port) and the sum goes through a restoring divider, one quotient bit
//   per cycle. After a window shrink leaves the write index past the
//   window, one more divider pass wraps the index.
//   One request is worked at a time; the next is taken in the cycle after
//   the result loads, even while that result still waits in the output
//   register.
//   Reset clears the configuration to its defaults, the write index and the
//   per-entry valid bits, so the store reads as zeros; no clearing sweep.
//   A stalled receiver holds the output register; the block then finishes
//   the next request and waits with it until the register frees.
// ----------------------------------------------------------------------------
module scaled_moving_average_filter #(
	parameter int DEPTH = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	smaf_sample_if.sink                    sample_ch,
	smaf_result_if.source                  result_ch,
	input  logic                           wr_en,
	input  logic [smaf_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [smaf_pkg::GAIN_W-1:0]    wr_data
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int WIN_W = $clog2(DEPTH + 1);
	localparam int SUM_W = smaf_pkg::VAL_W + $clog2(DEPTH);
	localparam int CMP_W = (WIN_W > smaf_pkg::WIN_W_REG) ? WIN_W : smaf_pkg::WIN_W_REG;

	// configuration
	logic                            filter_en_q;
	logic [smaf_pkg::WIN_W_REG-1:0]  window_q;
	logic [smaf_pkg::GAIN_W-1:0]     gain_q;

	// sequencer and store bookkeeping
	smaf_pkg::state_t                state_q, state_d;
	logic [IDX_W-1:0]                wr_idx_q;
	logic [DEPTH-1:0]                valid_q;
	logic [WIN_W-1:0]                rd_cnt_q;
	logic                            rd_vld_s1;
	logic                            vbit_s1;
	logic [SUM_W-1:0]                sum_q;
	logic [smaf_pkg::VAL_W-1:0]      result_q;
	logic                            out_valid_q;
	logic [smaf_pkg::VAL_W-1:0]      out_value_q;

	logic                            accept;
	logic                            mult_start;
	logic                            div_start;
	logic [SUM_W-1:0]                div_dividend;
	logic                            ram_we;
	logic                            rd_issue;
	logic                            ld_out;
	logic [CMP_W-1:0]                win_ext;
	logic [WIN_W-1:0]                eff_win;
	logic [WIN_W-1:0]                idx_inc;
	logic [IDX_W-1:0]                ram_raddr;
	logic [smaf_pkg::VAL_W-1:0]      ram_rdata;
	logic [smaf_pkg::VAL_W-1:0]      scaled;
	logic [smaf_pkg::PROD_W-1:0]     product;
	logic [SUM_W-1:0]                quotient;
	logic [WIN_W-1:0]                remainder;
	smaf_pkg::unit_sts_t             mult_sts;
	smaf_pkg::unit_sts_t             div_sts;

	// Clamp the window register to 1..DEPTH.
	always_comb begin
		win_ext = CMP_W'(window_q);
		if (win_ext == '0) begin
			eff_win = WIN_W'(1);
		end else if (win_ext > CMP_W'(DEPTH)) begin
			eff_win = WIN_W'(DEPTH);
		end else begin
			eff_win = WIN_W'(win_ext);
		end
	end

	assign idx_inc   = WIN_W'(wr_idx_q) + 1'b1;
	assign scaled    = product[smaf_pkg::PROD_W-1:smaf_pkg::FRAC_W];
	assign ram_raddr = rd_cnt_q[IDX_W-1:0];
	assign accept    = sample_ch.valid && sample_ch.ready;

	assign sample_ch.ready = (state_q == smaf_pkg::ST_IDLE);
	assign result_ch.valid = out_valid_q;
	assign result_ch.value = out_value_q;

	// Register writes; unknown indexes drop.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_en_q <= 1'b0;
			window_q    <= smaf_pkg::WINDOW_RESET;
			gain_q      <= smaf_pkg::GAIN_RESET;
		end else if (wr_en) begin
			case (smaf_pkg::cfg_reg_e'(wr_index))
				smaf_pkg::REG_FILTER_ENABLE: filter_en_q <= wr_data[0];
				smaf_pkg::REG_WINDOW:        window_q <= wr_data[smaf_pkg::WIN_W_REG-1:0];
				smaf_pkg::REG_GAIN:          gain_q <= wr_data;
				default: ;
			endcase
		end
	end

	smaf_mult u_mult (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mult_start),
		.raw     (sample_ch.raw_sample),
		.gain    (gain_q),
		.sts     (mult_sts),
		.product (product)
	);

	// Shared divider: sum by window, and wrapping the write index.
	smaf_div #(
		.N (SUM_W),
		.D (WIN_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (eff_win),
		.sts       (div_sts),
		.quotient  (quotient),
		.remainder (remainder)
	);

	smaf_ram #(
		.WIDTH (smaf_pkg::VAL_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_idx_q),
		.wdata (scaled),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Sequencer: next state and strobes.
	always_comb begin
		state_d      = state_q;
		mult_start   = 1'b0;
		div_start    = 1'b0;
		div_dividend = sum_q;
		ram_we       = 1'b0;
		rd_issue     = 1'b0;
		ld_out       = 1'b0;
		case (state_q)
			smaf_pkg::ST_IDLE: begin
				if (accept) begin
					mult_start = 1'b1;
					state_d    = smaf_pkg::ST_MUL;
				end
			end
			smaf_pkg::ST_MUL: begin
				if (mult_sts.done) begin
					state_d = filter_en_q ? smaf_pkg::ST_WRITE : smaf_pkg::ST_DONE;
				end
			end
			smaf_pkg::ST_WRITE: begin
				ram_we = 1'b1;
				// index beyond a shrunk window wraps through the divider
				if (idx_inc > eff_win) begin
					div_start    = 1'b1;
					div_dividend = SUM_W'(idx_inc);
					state_d      = smaf_pkg::ST_IMOD;
				end else begin
					state_d = smaf_pkg::ST_SUM;
				end
			end
			smaf_pkg::ST_IMOD: begin
				if (div_sts.done) begin
					state_d = smaf_pkg::ST_SUM;
				end
			end
			smaf_pkg::ST_SUM: begin
				rd_issue = (rd_cnt_q < eff_win);
				if (!rd_issue && !rd_vld_s1) begin
					state_d = smaf_pkg::ST_DIVS;
				end
			end
			smaf_pkg::ST_DIVS: begin
				div_start = 1'b1;
				state_d   = smaf_pkg::ST_DIVW;
			end
			smaf_pkg::ST_DIVW: begin
				if (div_sts.done) begin
					state_d = smaf_pkg::ST_DONE;
				end
			end
			smaf_pkg::ST_DONE: begin
				// hold until the output register frees
				if (!out_valid_q || result_ch.ready) begin
					ld_out  = 1'b1;
					state_d = smaf_pkg::ST_IDLE;
				end
			end
			default: state_d = smaf_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= smaf_pkg::ST_IDLE;
			wr_idx_q    <= '0;
			valid_q     <= '0;
			rd_cnt_q    <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_issue;
			if (state_q == smaf_pkg::ST_WRITE) begin
				valid_q[wr_idx_q] <= 1'b1;
				rd_cnt_q          <= '0;
				if (idx_inc < eff_win) begin
					wr_idx_q <= IDX_W'(idx_inc);
				end else if (idx_inc == eff_win) begin
					wr_idx_q <= '0;
				end
			end
			if (state_q == smaf_pkg::ST_IMOD && div_sts.done) begin
				wr_idx_q <= IDX_W'(remainder);
			end
			if (rd_issue) begin
				rd_cnt_q <= rd_cnt_q + 1'b1;
			end
			if (ld_out) begin
				out_valid_q <= 1'b1;
			end else if (result_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		vbit_s1 <= valid_q[ram_raddr];
		if (state_q == smaf_pkg::ST_WRITE) begin
			sum_q <= '0;
		end else if (rd_vld_s1) begin
			// entries never written count as zero
			sum_q <= sum_q + (vbit_s1 ? SUM_W'(ram_rdata) : '0);
		end
		if (state_q == smaf_pkg::ST_MUL && mult_sts.done && !filter_en_q) begin
			result_q <= scaled;
		end else if (state_q == smaf_pkg::ST_DIVW && div_sts.done) begin
			result_q <= quotient[smaf_pkg::VAL_W-1:0];
		end
		if (ld_out) begin
			out_value_q <= result_q;
		end
	end

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------
	a_idx_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == smaf_pkg::ST_SUM) |-> (WIN_W'(wr_idx_q) < eff_win))
		else $error("write index outside the window during the sum sweep");

	a_sweep_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == smaf_pkg::ST_SUM) |-> (rd_cnt_q <= eff_win))
		else $error("sum sweep ran past the window");

	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_sts.busy |-> (state_q == smaf_pkg::ST_IMOD || state_q == smaf_pkg::ST_DIVW))
		else $error("divider busy outside a divide state");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == smaf_pkg::ST_DONE))
		else $error("output loaded without a finished request");

endmodule
